>>> sv/vpct_pkg.sv
// shared types, constants and helpers for the verlet particle table
package vpct_pkg;

	localparam int PARTICLE_COUNT = 1024;
	localparam int ADDR_W = $clog2(PARTICLE_COUNT);
	localparam int FRAC_BITS = 16;
	localparam int COEF_BITS = 16;
	localparam int MUL_W = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ITER_STEPS = 32;
	localparam int STEP_W = $clog2(ITER_STEPS);

	localparam logic [63:0] PC_NUM = 64'd1 << (COEF_BITS + FRAC_BITS);
	localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_ACCEL = 3'd1;
	localparam logic [2:0] OP_INTEGRATE = 3'd2;
	localparam logic [2:0] OP_CONSTRAIN = 3'd3;
	localparam logic [2:0] OP_COLLIDE = 3'd4;
	localparam logic [2:0] OP_READ = 3'd5;

	localparam logic [2:0] CFG_DT_SQUARED = 3'd0;
	localparam logic [2:0] CFG_BOX_MIN_X = 3'd1;
	localparam logic [2:0] CFG_BOX_MIN_Y = 3'd2;
	localparam logic [2:0] CFG_BOX_MAX_X = 3'd3;
	localparam logic [2:0] CFG_BOX_MAX_Y = 3'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [9:0] index_a;
		logic [9:0] index_b;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] prior_x;
		logic signed [31:0] prior_y;
		logic [30:0] radius_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [30:0] pressure_out;
		logic [16:0] coef_out;
		logic contact;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] cur_x;
		logic signed [31:0] cur_y;
		logic signed [31:0] prev_x;
		logic signed [31:0] prev_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic [30:0] radius;
		logic [30:0] pressure;
		logic [16:0] coef;
	} particle_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		particle_t data;
	} mem_wr_t;

	typedef struct packed {
		logic start;
		logic sqrt_mode;
		logic [63:0] num;
		logic [63:0] den;
	} iter_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [31:0] result;
	} iter_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -40'sh0080000000)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic [30:0] add_pressure(input logic [30:0] p, input logic [30:0] inc);
		logic [31:0] s;
		s = {1'b0, p} + {1'b0, inc};
		return s[31] ? 31'h7FFFFFFF : s[30:0];
	endfunction

endpackage

>>> sv/vpct_mem.sv
// particle table memory, one write port and one registered read port
module vpct_mem (
	input logic clk,
	input logic [vpct_pkg::ADDR_W-1:0] rd_addr,
	output vpct_pkg::particle_t rd_data,
	input vpct_pkg::mem_wr_t wr
);

	vpct_pkg::particle_t mem_q [vpct_pkg::PARTICLE_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> sv/vpct_mul.sv
// shared signed multiplier with registered product
module vpct_mul (
	input logic clk,
	input logic signed [vpct_pkg::MUL_W-1:0] a,
	input logic signed [vpct_pkg::MUL_W-1:0] b,
	output logic signed [vpct_pkg::PROD_W-1:0] product_q
);

	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

endmodule

>>> sv/vpct_iter.sv
// iterative unit: restoring divide or integer square root, one bit per cycle
module vpct_iter (
	input logic clk,
	input logic arst_n,
	input vpct_pkg::iter_cmd_t cmd,
	output vpct_pkg::iter_rsp_t rsp
);

	logic [65:0] rem_q;
	logic [63:0] low_q;
	logic [31:0] quo_q;
	logic [63:0] den_q;
	logic sqrt_q;
	logic busy_q;
	logic done_q;
	logic [vpct_pkg::STEP_W-1:0] cnt_q;

	logic [65:0] shifted;
	logic [65:0] trial;
	logic take;

	// one shared compare and subtract for both modes
	always_comb begin
		if (sqrt_q) begin
			shifted = {rem_q[63:0], low_q[63:62]};
			trial = {32'b0, quo_q, 2'b01};
		end else begin
			shifted = {rem_q[64:0], low_q[63]};
			trial = {2'b0, den_q};
		end
		take = shifted >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == vpct_pkg::STEP_W'(vpct_pkg::ITER_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.sqrt_mode;
			den_q <= cmd.den;
			quo_q <= '0;
			if (cmd.sqrt_mode) begin
				rem_q <= '0;
				low_q <= cmd.num;
			end else begin
				rem_q <= {34'b0, cmd.num[63:32]};
				low_q <= {cmd.num[31:0], 32'b0};
			end
		end else if (busy_q) begin
			rem_q <= take ? shifted - trial : shifted;
			quo_q <= {quo_q[30:0], take};
			low_q <= sqrt_q ? {low_q[61:0], 2'b00} : {low_q[62:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.result = quo_q;

endmodule

>>> sv/verlet_particle_collision_table_unit.sv
// Verlet particle table: one request runs one operation on an entry of the table (on two for
// collide) and returns one response with entry a afterwards. The block takes one request at a
// time and holds req_stall high until its work is done; the response sits in an output
// register so the next request can enter while it waits. Load, accelerate and constrain run a
// memory read, an update and a memory write; read and the unused codes run the memory read only.
// Integrate adds the 32-step reciprocal of the shared divide/square-root unit and five passes
// through the shared multiplier. Collide can add a 32-step square root and two 32-step divides
// on the same unit and five multiplier passes. A response still stalled in the output register
// holds the next response back. The table needs no clearing pass after reset; an entry must be
// loaded before it is used. Configuration writes are always taken.
module verlet_particle_collision_table_unit (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input vpct_pkg::req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output vpct_pkg::rsp_t rsp_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RA = 5'd1;
	localparam logic [4:0] ST_LA = 5'd2;
	localparam logic [4:0] ST_UPD = 5'd3;
	localparam logic [4:0] ST_WA = 5'd4;
	localparam logic [4:0] ST_WB = 5'd5;
	localparam logic [4:0] ST_FIN = 5'd6;
	localparam logic [4:0] ST_I_PP = 5'd7;
	localparam logic [4:0] ST_I_DS = 5'd8;
	localparam logic [4:0] ST_I_DW = 5'd9;
	localparam logic [4:0] ST_I_AX = 5'd10;
	localparam logic [4:0] ST_I_AY = 5'd11;
	localparam logic [4:0] ST_I_MX = 5'd12;
	localparam logic [4:0] ST_I_MY = 5'd13;
	localparam logic [4:0] ST_I_FIN = 5'd14;
	localparam logic [4:0] ST_C_RB = 5'd15;
	localparam logic [4:0] ST_C_LB = 5'd16;
	localparam logic [4:0] ST_C_DX = 5'd17;
	localparam logic [4:0] ST_C_DY = 5'd18;
	localparam logic [4:0] ST_C_RS = 5'd19;
	localparam logic [4:0] ST_C_CMP = 5'd20;
	localparam logic [4:0] ST_C_SW = 5'd21;
	localparam logic [4:0] ST_C_CHK = 5'd22;
	localparam logic [4:0] ST_C_MX = 5'd23;
	localparam logic [4:0] ST_C_XS = 5'd24;
	localparam logic [4:0] ST_C_XW = 5'd25;
	localparam logic [4:0] ST_C_MY = 5'd26;
	localparam logic [4:0] ST_C_YS = 5'd27;
	localparam logic [4:0] ST_C_YW = 5'd28;
	localparam logic [4:0] ST_C_UPD = 5'd29;

	logic [4:0] state_q;
	vpct_pkg::req_t req_q;
	vpct_pkg::particle_t ent_a_q;
	vpct_pkg::particle_t ent_b_q;
	vpct_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic contact_q;

	logic [31:0] dt_q;
	logic signed [31:0] min_x_q;
	logic signed [31:0] min_y_q;
	logic signed [31:0] max_x_q;
	logic signed [31:0] max_y_q;

	logic [16:0] pc_q;
	logic signed [31:0] ax_q;
	logic signed [31:0] ay_q;
	logic signed [35:0] mx_q;
	logic signed [31:0] dx_q;
	logic signed [31:0] dy_q;
	logic [63:0] n2_q;
	logic [31:0] dist_q;
	logic [30:0] delta_q;
	logic signed [32:0] px_q;
	logic signed [32:0] py_q;

	vpct_pkg::particle_t rd_data;
	vpct_pkg::mem_wr_t mem_wr;
	logic [vpct_pkg::ADDR_W-1:0] rd_addr;

	logic signed [vpct_pkg::MUL_W-1:0] mul_a;
	logic signed [vpct_pkg::MUL_W-1:0] mul_b;
	logic signed [vpct_pkg::PROD_W-1:0] prod_q;

	vpct_pkg::iter_cmd_t iter_cmd;
	vpct_pkg::iter_rsp_t iter_rsp;

	logic signed [31:0] dx_c;
	logic signed [31:0] dy_c;
	logic [31:0] rs_c;
	logic signed [32:0] adx_c;
	logic signed [32:0] ady_c;
	logic signed [33:0] sum_x_c;
	logic signed [33:0] sum_y_c;
	logic signed [39:0] rad_c;
	logic signed [39:0] cx_c;
	logic signed [39:0] cy_c;
	vpct_pkg::particle_t simple_c;

	vpct_mem u_mem (
		.clk(clk),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr(mem_wr)
	);

	vpct_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.product_q(prod_q)
	);

	vpct_iter u_iter (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(iter_cmd),
		.rsp(iter_rsp)
	);

	assign req_stall = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= 32'd1193046;
			min_x_q <= 32'sd0;
			min_y_q <= 32'sd0;
			max_x_q <= 32'sd52428800;
			max_y_q <= 32'sd39321600;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vpct_pkg::CFG_DT_SQUARED: dt_q <= cfg_data;
				vpct_pkg::CFG_BOX_MIN_X: min_x_q <= cfg_data;
				vpct_pkg::CFG_BOX_MIN_Y: min_y_q <= cfg_data;
				vpct_pkg::CFG_BOX_MAX_X: max_x_q <= cfg_data;
				vpct_pkg::CFG_BOX_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// operand and helper logic
	always_comb begin
		dx_c = vpct_pkg::sat32(40'(ent_a_q.cur_x) - 40'(ent_b_q.cur_x));
		dy_c = vpct_pkg::sat32(40'(ent_a_q.cur_y) - 40'(ent_b_q.cur_y));
		rs_c = {1'b0, ent_a_q.radius} + {1'b0, ent_b_q.radius};
		adx_c = dx_q[31] ? -33'(dx_q) : 33'(dx_q);
		ady_c = dy_q[31] ? -33'(dy_q) : 33'(dy_q);
		sum_x_c = 34'(ent_a_q.cur_x) - 34'(ent_a_q.prev_x) + 34'(ax_q);
		sum_y_c = 34'(ent_a_q.cur_y) - 34'(ent_a_q.prev_y) + 34'(ay_q);
		rad_c = $signed({9'b0, ent_a_q.radius});
		cx_c = 40'(ent_a_q.cur_x);
		cy_c = 40'(ent_a_q.cur_y);

		simple_c = ent_a_q;
		unique case (req_q.operation)
			vpct_pkg::OP_LOAD: begin
				simple_c.cur_x = req_q.value_x;
				simple_c.cur_y = req_q.value_y;
				simple_c.prev_x = req_q.prior_x;
				simple_c.prev_y = req_q.prior_y;
				simple_c.radius = req_q.radius_in;
				simple_c.acc_x = '0;
				simple_c.acc_y = '0;
				simple_c.pressure = '0;
			end
			vpct_pkg::OP_ACCEL: begin
				simple_c.acc_x = vpct_pkg::sat32(40'(ent_a_q.acc_x) + 40'(req_q.value_x));
				simple_c.acc_y = vpct_pkg::sat32(40'(ent_a_q.acc_y) + 40'(req_q.value_y));
			end
			vpct_pkg::OP_CONSTRAIN: begin
				// the min edge wins when both tests fire
				if (cx_c - rad_c < 40'(min_x_q))
					simple_c.cur_x = vpct_pkg::sat32(40'(min_x_q) + rad_c);
				else if (cx_c + rad_c > 40'(max_x_q))
					simple_c.cur_x = vpct_pkg::sat32(40'(max_x_q) - rad_c);
				if (cy_c - rad_c < 40'(min_y_q))
					simple_c.cur_y = vpct_pkg::sat32(40'(min_y_q) + rad_c);
				else if (cy_c + rad_c > 40'(max_y_q))
					simple_c.cur_y = vpct_pkg::sat32(40'(max_y_q) - rad_c);
			end
			default: ;
		endcase

		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_I_PP: begin
				mul_a = $signed({3'b0, ent_a_q.pressure});
				mul_b = $signed({3'b0, ent_a_q.pressure});
			end
			ST_I_AX: begin
				mul_a = 34'(ent_a_q.acc_x);
				mul_b = $signed({2'b0, dt_q});
			end
			ST_I_AY: begin
				mul_a = 34'(ent_a_q.acc_y);
				mul_b = $signed({2'b0, dt_q});
			end
			ST_I_MX: begin
				mul_a = sum_x_c;
				mul_b = $signed({17'b0, pc_q});
			end
			ST_I_MY: begin
				mul_a = sum_y_c;
				mul_b = $signed({17'b0, pc_q});
			end
			ST_C_DX: begin
				mul_a = 34'(dx_c);
				mul_b = 34'(dx_c);
			end
			ST_C_DY: begin
				mul_a = 34'(dy_c);
				mul_b = 34'(dy_c);
			end
			ST_C_RS: begin
				mul_a = $signed({2'b0, rs_c});
				mul_b = $signed({2'b0, rs_c});
			end
			ST_C_MX: begin
				mul_a = 34'(adx_c);
				mul_b = $signed({3'b0, delta_q});
			end
			ST_C_MY: begin
				mul_a = 34'(ady_c);
				mul_b = $signed({3'b0, delta_q});
			end
			default: ;
		endcase

		iter_cmd.start = 1'b0;
		iter_cmd.sqrt_mode = 1'b0;
		iter_cmd.num = prod_q[63:0];
		iter_cmd.den = {32'b0, dist_q};
		unique case (state_q)
			ST_I_DS: begin
				iter_cmd.start = 1'b1;
				iter_cmd.num = vpct_pkg::PC_NUM;
				iter_cmd.den = vpct_pkg::ONE_Q + (prod_q[63:0] >> vpct_pkg::FRAC_BITS);
			end
			ST_C_CMP: begin
				iter_cmd.start = n2_q <= prod_q[63:0];
				iter_cmd.sqrt_mode = 1'b1;
				iter_cmd.num = n2_q;
			end
			ST_C_XS, ST_C_YS: iter_cmd.start = 1'b1;
			default: ;
		endcase

		rd_addr = (state_q == ST_C_RB) ? req_q.index_b[vpct_pkg::ADDR_W-1:0]
			: req_q.index_a[vpct_pkg::ADDR_W-1:0];
		mem_wr.en = (state_q == ST_WA) || (state_q == ST_WB);
		mem_wr.addr = (state_q == ST_WB) ? req_q.index_b[vpct_pkg::ADDR_W-1:0]
			: req_q.index_a[vpct_pkg::ADDR_W-1:0];
		mem_wr.data = (state_q == ST_WB) ? ent_b_q : ent_a_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			contact_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != ST_FIN)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						contact_q <= 1'b0;
						state_q <= ST_RA;
					end
				end
				ST_RA: state_q <= ST_LA;
				ST_LA: begin
					priority case (req_q.operation)
						vpct_pkg::OP_LOAD, vpct_pkg::OP_ACCEL, vpct_pkg::OP_CONSTRAIN:
							state_q <= ST_UPD;
						vpct_pkg::OP_INTEGRATE: state_q <= ST_I_PP;
						vpct_pkg::OP_COLLIDE: state_q <= ST_C_RB;
						default: state_q <= ST_FIN;
					endcase
				end
				ST_UPD: state_q <= ST_WA;
				ST_WA: state_q <= contact_q ? ST_WB : ST_FIN;
				ST_WB: state_q <= ST_FIN;
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_I_PP: state_q <= ST_I_DS;
				ST_I_DS: state_q <= ST_I_DW;
				ST_I_DW: if (iter_rsp.done) state_q <= ST_I_AX;
				ST_I_AX: state_q <= ST_I_AY;
				ST_I_AY: state_q <= ST_I_MX;
				ST_I_MX: state_q <= ST_I_MY;
				ST_I_MY: state_q <= ST_I_FIN;
				ST_I_FIN: state_q <= ST_WA;
				ST_C_RB: state_q <= ST_C_LB;
				ST_C_LB: state_q <= ST_C_DX;
				ST_C_DX: state_q <= ST_C_DY;
				ST_C_DY: state_q <= ST_C_RS;
				ST_C_RS: state_q <= ST_C_CMP;
				ST_C_CMP: state_q <= (n2_q > prod_q[63:0]) ? ST_FIN : ST_C_SW;
				ST_C_SW: if (iter_rsp.done) state_q <= ST_C_CHK;
				ST_C_CHK: begin
					if (dist_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						contact_q <= 1'b1;
						state_q <= ST_C_MX;
					end
				end
				ST_C_MX: state_q <= ST_C_XS;
				ST_C_XS: state_q <= ST_C_XW;
				ST_C_XW: if (iter_rsp.done) state_q <= ST_C_MY;
				ST_C_MY: state_q <= ST_C_YS;
				ST_C_YS: state_q <= ST_C_YW;
				ST_C_YW: if (iter_rsp.done) state_q <= ST_C_UPD;
				ST_C_UPD: state_q <= ST_WA;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (req_valid) req_q <= req_data;
			ST_LA: ent_a_q <= rd_data;
			ST_UPD: ent_a_q <= simple_c;
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.pos_x <= ent_a_q.cur_x;
					rsp_q.pos_y <= ent_a_q.cur_y;
					rsp_q.pressure_out <= ent_a_q.pressure;
					rsp_q.coef_out <= ent_a_q.coef;
					rsp_q.contact <= contact_q;
				end
			end
			ST_I_DW: if (iter_rsp.done) pc_q <= iter_rsp.result[16:0];
			ST_I_AY: ax_q <= prod_q[63:32];
			ST_I_MX: ay_q <= prod_q[63:32];
			ST_I_MY: mx_q <= prod_q[vpct_pkg::COEF_BITS+35:vpct_pkg::COEF_BITS];
			ST_I_FIN: begin
				ent_a_q.prev_x <= ent_a_q.cur_x;
				ent_a_q.prev_y <= ent_a_q.cur_y;
				ent_a_q.cur_x <= vpct_pkg::sat32(40'(ent_a_q.cur_x) + 40'(mx_q));
				ent_a_q.cur_y <= vpct_pkg::sat32(40'(ent_a_q.cur_y)
					+ 40'($signed(prod_q[vpct_pkg::COEF_BITS+35:vpct_pkg::COEF_BITS])));
				ent_a_q.coef <= pc_q;
				ent_a_q.pressure <= '0;
			end
			ST_C_LB: ent_b_q <= rd_data;
			ST_C_DX: dx_q <= dx_c;
			ST_C_DY: begin
				dy_q <= dy_c;
				n2_q <= prod_q[63:0];
			end
			ST_C_RS: n2_q <= n2_q + prod_q[63:0];
			ST_C_SW: if (iter_rsp.done) dist_q <= iter_rsp.result;
			ST_C_CHK: delta_q <= 31'((rs_c - dist_q) >> 1);
			ST_C_XW: begin
				if (iter_rsp.done)
					px_q <= dx_q[31] ? -$signed({1'b0, iter_rsp.result})
						: $signed({1'b0, iter_rsp.result});
			end
			ST_C_YW: begin
				if (iter_rsp.done)
					py_q <= dy_q[31] ? -$signed({1'b0, iter_rsp.result})
						: $signed({1'b0, iter_rsp.result});
			end
			ST_C_UPD: begin
				ent_a_q.cur_x <= vpct_pkg::sat32(40'(ent_a_q.cur_x) + 40'(px_q));
				ent_a_q.cur_y <= vpct_pkg::sat32(40'(ent_a_q.cur_y) + 40'(py_q));
				ent_b_q.cur_x <= vpct_pkg::sat32(40'(ent_b_q.cur_x) - 40'(px_q));
				ent_b_q.cur_y <= vpct_pkg::sat32(40'(ent_b_q.cur_y) - 40'(py_q));
				ent_a_q.pressure <= vpct_pkg::add_pressure(ent_a_q.pressure,
					{1'b0, delta_q[30:1]});
				ent_b_q.pressure <= vpct_pkg::add_pressure(ent_b_q.pressure,
					{1'b0, delta_q[30:1]});
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_stall_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> req_stall)
		else $error("request taken while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		iter_rsp.done |-> (state_q == ST_I_DW || state_q == ST_C_SW
			|| state_q == ST_C_XW || state_q == ST_C_YW))
		else $error("iterative unit finished outside a wait state");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		iter_cmd.start |-> !iter_rsp.busy)
		else $error("iterative unit restarted while busy");

	a_second_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> ($past(state_q) == ST_WA && contact_q))
		else $error("entry b written without a contact");
`endif

endmodule

>>> test/tb_top.sv
// self-checking testbench for the verlet particle collision table unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int POOL_N = 16;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	vpct_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	vpct_pkg::rsp_t rsp_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	verlet_particle_collision_table_unit uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// mirror of the particle table and registers
	logic signed [31:0] cx [vpct_pkg::PARTICLE_COUNT];
	logic signed [31:0] cy [vpct_pkg::PARTICLE_COUNT];
	logic signed [31:0] px [vpct_pkg::PARTICLE_COUNT];
	logic signed [31:0] py [vpct_pkg::PARTICLE_COUNT];
	logic signed [31:0] ax [vpct_pkg::PARTICLE_COUNT];
	logic signed [31:0] ay [vpct_pkg::PARTICLE_COUNT];
	logic [30:0] rad [vpct_pkg::PARTICLE_COUNT];
	logic [30:0] prs [vpct_pkg::PARTICLE_COUNT];
	logic [16:0] cf [vpct_pkg::PARTICLE_COUNT];
	bit loaded [vpct_pkg::PARTICLE_COUNT];
	logic [31:0] dt_sq = 32'd1193046;
	logic signed [31:0] bmin_x = 0, bmin_y = 0, bmax_x = 52428800, bmax_y = 39321600;

	vpct_pkg::rsp_t expected_rsp [$];
	int errors = 0;
	int checked = 0;
	int contacts = 0;
	int op_seen [8];
	bit quiet = 0;
	longint cycles = 0;
	int pool [POOL_N];

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic [30:0] bump_pressure(logic [30:0] p, longint unsigned inc);
		longint unsigned s;
		s = longint'(p) + inc;
		return (s > 64'h7FFFFFFF) ? 31'h7FFFFFFF : s[30:0];
	endfunction

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// advances the mirror by one request and returns the response it should give
	function automatic vpct_pkg::rsp_t table_step(vpct_pkg::req_t r);
		vpct_pkg::rsp_t o;
		int a, b;
		longint p, pc, vx, vy, gx, gy, mx, my, x, y, rr, nx, ny, dx, dy, sx, sy;
		longint unsigned n2, rs, root_len, delta;
		bit hit;
		a = int'(r.index_a);
		b = int'(r.index_b);
		hit = 0;
		case (r.operation)
			vpct_pkg::OP_LOAD: begin
				cx[a] = r.value_x;
				cy[a] = r.value_y;
				px[a] = r.prior_x;
				py[a] = r.prior_y;
				rad[a] = r.radius_in;
				ax[a] = 0;
				ay[a] = 0;
				prs[a] = 0;
				loaded[a] = 1;
			end
			vpct_pkg::OP_ACCEL: begin
				ax[a] = clip32(longint'(ax[a]) + longint'(r.value_x));
				ay[a] = clip32(longint'(ay[a]) + longint'(r.value_y));
			end
			vpct_pkg::OP_INTEGRATE: begin
				p = longint'(prs[a]);
				pc = (64'sd1 << (vpct_pkg::COEF_BITS + vpct_pkg::FRAC_BITS))
					/ ((64'sd1 << vpct_pkg::FRAC_BITS) + ((p * p) >>> vpct_pkg::FRAC_BITS));
				vx = longint'(cx[a]) - longint'(px[a]);
				vy = longint'(cy[a]) - longint'(py[a]);
				gx = (longint'(ax[a]) * longint'({32'd0, dt_sq})) >>> 32;
				gy = (longint'(ay[a]) * longint'({32'd0, dt_sq})) >>> 32;
				mx = ((vx + gx) * pc) >>> vpct_pkg::COEF_BITS;
				my = ((vy + gy) * pc) >>> vpct_pkg::COEF_BITS;
				px[a] = cx[a];
				py[a] = cy[a];
				cx[a] = clip32(longint'(cx[a]) + mx);
				cy[a] = clip32(longint'(cy[a]) + my);
				cf[a] = pc[16:0];
				prs[a] = 0;
			end
			vpct_pkg::OP_CONSTRAIN: begin
				x = cx[a];
				y = cy[a];
				rr = longint'(rad[a]);
				nx = x;
				ny = y;
				// both limits are tested against the old position, min wins
				if (x + rr > bmax_x) nx = longint'(bmax_x) - rr;
				if (y + rr > bmax_y) ny = longint'(bmax_y) - rr;
				if (x - rr < bmin_x) nx = longint'(bmin_x) + rr;
				if (y - rr < bmin_y) ny = longint'(bmin_y) + rr;
				cx[a] = clip32(nx);
				cy[a] = clip32(ny);
			end
			vpct_pkg::OP_COLLIDE: begin
				dx = clip32(longint'(cx[a]) - longint'(cx[b]));
				dy = clip32(longint'(cy[a]) - longint'(cy[b]));
				n2 = longint'(dx * dx) + longint'(dy * dy);
				rs = longint'(rad[a]) + longint'(rad[b]);
				if (n2 <= rs * rs) begin
					root_len = root64(n2);
					if (root_len != 0) begin
						delta = (rs - root_len) >> 1;
						sx = (dx * longint'(delta)) / longint'(root_len);
						sy = (dy * longint'(delta)) / longint'(root_len);
						cx[a] = clip32(longint'(cx[a]) + sx);
						cy[a] = clip32(longint'(cy[a]) + sy);
						cx[b] = clip32(longint'(cx[b]) - sx);
						cy[b] = clip32(longint'(cy[b]) - sy);
						prs[a] = bump_pressure(prs[a], delta >> 1);
						prs[b] = bump_pressure(prs[b], delta >> 1);
						hit = 1;
					end
				end
			end
			default: ;
		endcase
		o.pos_x = cx[a];
		o.pos_y = cy[a];
		o.pressure_out = prs[a];
		o.coef_out = cf[a];
		o.contact = hit;
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	// response side: random stall and in-order compare
	int stall_left = 0;
	always @(posedge clk) begin
		vpct_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected response", 1, 0);
			end else begin
				want = expected_rsp.pop_front();
				checked++;
				if (rsp_data.pos_x !== want.pos_x)
					report_mismatch("pos_x", rsp_data.pos_x, want.pos_x);
				if (rsp_data.pos_y !== want.pos_y)
					report_mismatch("pos_y", rsp_data.pos_y, want.pos_y);
				if (rsp_data.pressure_out !== want.pressure_out)
					report_mismatch("pressure_out", rsp_data.pressure_out, want.pressure_out);
				if (rsp_data.coef_out !== want.coef_out)
					report_mismatch("coef_out", rsp_data.coef_out, want.coef_out);
				if (rsp_data.contact !== want.contact)
					report_mismatch("contact", rsp_data.contact, want.contact);
				if (want.contact)
					contacts++;
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1;
		end else begin
			stall_left <= gap_len();
			rsp_stall <= 0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(vpct_pkg::req_t r);
		req_valid <= 1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		op_seen[r.operation]++;
		expected_rsp.push_back(table_step(r));
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			req_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		pause_sender(1);
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			vpct_pkg::CFG_DT_SQUARED: dt_sq = val;
			vpct_pkg::CFG_BOX_MIN_X: bmin_x = val;
			vpct_pkg::CFG_BOX_MIN_Y: bmin_y = val;
			vpct_pkg::CFG_BOX_MAX_X: bmax_x = val;
			vpct_pkg::CFG_BOX_MAX_Y: bmax_y = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] dt, logic [31:0] x0, logic [31:0] y0,
			logic [31:0] x1, logic [31:0] y1);
		drain();
		write_reg(vpct_pkg::CFG_DT_SQUARED, dt);
		write_reg(vpct_pkg::CFG_BOX_MIN_X, x0);
		write_reg(vpct_pkg::CFG_BOX_MIN_Y, y0);
		write_reg(vpct_pkg::CFG_BOX_MAX_X, x1);
		write_reg(vpct_pkg::CFG_BOX_MAX_Y, y1);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic vpct_pkg::req_t mk(logic [2:0] op, int a, int b, logic [31:0] vx,
			logic [31:0] vy, logic [31:0] qx, logic [31:0] qy, logic [31:0] r);
		vpct_pkg::req_t q;
		q.operation = op;
		q.index_a = 10'(a);
		q.index_b = 10'(b);
		q.value_x = vx;
		q.value_y = vy;
		q.prior_x = qx;
		q.prior_y = qy;
		q.radius_in = r[30:0];
		return q;
	endfunction

	task automatic test_directed();
		quiet = 1;
		send_request(mk(vpct_pkg::OP_LOAD, 0, 1023, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF));
		send_request(mk(vpct_pkg::OP_LOAD, 1023, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_LOAD, 5, 0, 10 << 16, 10 << 16, 9 << 16, 11 << 16,
			3 << 16));
		send_request(mk(vpct_pkg::OP_LOAD, 6, 0, 12 << 16, 11 << 16, 12 << 16, 11 << 16,
			3 << 16));
		// saturating acceleration
		send_request(mk(vpct_pkg::OP_ACCEL, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_ACCEL, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_ACCEL, 5, 0, 2 << 16, 32'hFFFF0000, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_INTEGRATE, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_INTEGRATE, 5, 0, 0, 0, 0, 0, 0));
		// overlap, same entry, coincident entries
		send_request(mk(vpct_pkg::OP_COLLIDE, 5, 6, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_COLLIDE, 6, 5, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_COLLIDE, 5, 5, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_LOAD, 7, 0, 10 << 16, 10 << 16, 0, 0, 1));
		send_request(mk(vpct_pkg::OP_LOAD, 8, 0, 10 << 16, 10 << 16, 0, 0, 1));
		send_request(mk(vpct_pkg::OP_COLLIDE, 7, 8, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_COLLIDE, 0, 1023, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_INTEGRATE, 5, 0, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_CONSTRAIN, 0, 0, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_CONSTRAIN, 1023, 0, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_CONSTRAIN, 6, 0, 0, 0, 0, 0, 0));
		send_request(mk(vpct_pkg::OP_READ, 1023, 0, 0, 0, 0, 0, 0));
		send_request(mk(3'd6, 5, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
		send_request(mk(3'd7, 6, 0, 0, 0, 0, 0, 0));
		quiet = 0;
	endtask

	task automatic pick_pool();
		pool[0] = 0;
		pool[1] = 1023;
		for (int i = 2; i < POOL_N; i++)
			pool[i] = $urandom_range(0, 1023);
	endtask

	// mostly clustered particles so collisions happen; some full-range noise
	task automatic test_random(int n);
		vpct_pkg::req_t q;
		int a, b, sel;
		logic [31:0] bx, by;
		pick_pool();
		for (int k = 0; k < n; k++) begin
			a = pool[$urandom_range(0, POOL_N - 1)];
			b = pool[$urandom_range(0, POOL_N - 1)];
			sel = $urandom_range(0, 99);
			q = mk(vpct_pkg::OP_READ, a, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
				$urandom, $urandom);
			if (!loaded[a] || sel < 15) begin
				q.operation = vpct_pkg::OP_LOAD;
				if (sel % 5 != 0) begin
					bx = $urandom_range(10, 40) << 16 | $urandom_range(0, 65535);
					by = $urandom_range(10, 40) << 16 | $urandom_range(0, 65535);
					q.value_x = bx;
					q.value_y = by;
					q.prior_x = bx + $urandom_range(0, 2 << 16) - (1 << 16);
					q.prior_y = by + $urandom_range(0, 2 << 16) - (1 << 16);
					q.radius_in = 31'($urandom_range(1 << 16, 6 << 16));
				end
			end else if (sel < 30) begin
				q.operation = vpct_pkg::OP_ACCEL;
				if (sel % 4 != 0) begin
					q.value_x = $urandom_range(0, 20 << 16) - (10 << 16);
					q.value_y = $urandom_range(0, 20 << 16) - (10 << 16);
				end
			end else if (sel < 48) begin
				q.operation = vpct_pkg::OP_INTEGRATE;
			end else if (sel < 62) begin
				q.operation = vpct_pkg::OP_CONSTRAIN;
			end else if (sel < 92 && loaded[b]) begin
				q.operation = vpct_pkg::OP_COLLIDE;
				q.index_b = 10'(b);
			end else if (sel < 96) begin
				q.operation = vpct_pkg::OP_READ;
			end else begin
				q.operation = 3'($urandom_range(6, 7));
			end
			send_request(q);
			pause_sender(gap_len());
		end
	endtask

	task automatic test_quiet_burst(int n);
		quiet = 1;
		test_random(n);
		quiet = 0;
	endtask

	task automatic test_drain_pause();
		test_random(20);
		// sender holds off until the block has answered everything
		drain();
		test_random(20);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(300);
		set_config(32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
		test_directed();
		test_random(250);
		set_config(32'd0, 20 << 16, 20 << 16, 30 << 16, 30 << 16);
		test_random(250);
		set_config(32'd65536, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		test_quiet_burst(150);
		set_config($urandom, 15 << 16, 12 << 16, 35 << 16, 33 << 16);
		test_drain_pause();
		test_random(350);
		drain();
		repeat (200) @(posedge clk);
		$display("ran load %0d, accelerate %0d, integrate %0d, constrain %0d, collide %0d,",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
		$display("read %0d, unused codes %0d; %0d responses checked, %0d contacts",
			op_seen[5], op_seen[6] + op_seen[7], checked, contacts);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
